// ===== rtl/pcurv_pkg.sv =====
// pcurv_pkg: types and constants for the pure pursuit curvature pipeline
// used by pursuit_curvature; no dependencies
`default_nettype none

package pcurv_pkg;

  // fixed field widths
  localparam int POS_W  = 24;
  localparam int HEAD_W = 16;
  localparam int DX_W   = 25;
  localparam int CURV_W = 32;

  // sine / cosine core, Q30 words
  localparam int T_W    = 14;
  localparam int XP_W   = 48;
  localparam int X_W    = 30;
  localparam int XSQ_W  = 61;
  localparam int H_W    = 31;
  localparam int HP_W   = 61;
  localparam int M_W    = 32;
  localparam int PM_W   = 63;
  localparam logic [H_W-1:0] Q30_ONE = 31'h4000_0000;
  localparam logic [33:0]    PI_Q32  = 34'd13493037705;
  localparam logic [T_W-1:0] OCTANT  = 14'd8192;

  // horner steps and their divisors
  localparam int HSTEPS = 6;
  localparam logic [7:0] SDIV [HSTEPS] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
  localparam logic [7:0] CDIV [HSTEPS] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};

  // quadrant codes of the heading
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // divider
  localparam int SQ_W  = 49;
  localparam int DEN_W = 50;
  localparam int REM_W = 53;
  localparam int QBITS = 32;
  localparam int CMP_W = DEN_W + QBITS + 1;

  // sideband through the sine / cosine stages
  typedef struct packed {
    logic                   valid;
    logic                   coinc;
    logic [1:0]             quad;
    logic                   mirror;
    logic signed [DX_W-1:0] dx;
    logic signed [DX_W-1:0] dy;
    logic [X_W-1:0]         x;
    logic [X_W-1:0]         x2;
  } side_t;

  // one stage of the restoring divider
  typedef struct packed {
    logic             valid;
    logic             coinc;
    logic             neg;
    logic             ovf;
    logic [DEN_W-1:0] den;
    logic [REM_W-1:0] rem;
    logic [QBITS-1:0] q;
  } div_t;

  // pass a sideband word on, dropping its valid bit under reset
  function automatic side_t side_pass(side_t v, logic kill);
    side_t r;
    r       = v;
    r.valid = v.valid && !kill;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/pursuit_curvature.sv =====
// pursuit_curvature: pipelined pure pursuit curvature, Q7.24 result
// depends on pcurv_pkg (types, widths, horner divisors)
//
//  channel   ports                                         beat marked by
//  input     robot_x robot_y heading target_x target_y     start && !busy
//  result    curvature saturated coincident                done (one cycle)
//
// a beat enters every cycle; busy is always low
// the pipeline registers, LAT in all, are 5 angle stages, 3 per horner step of the
// sine / cosine core (6 steps), 2 rounding, 3 cross product, 1 + 32 divider
// stages (one quotient bit each) and one round / clip stage
// synchronous reset clears the valid bits of every stage
// the receiver cannot stall, so the pipeline never holds
`default_nettype none

module pursuit_curvature #(
  parameter int SINE_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic signed [23:0]   robot_x,
  input  wire logic signed [23:0]   robot_y,
  input  wire logic        [15:0]   heading,
  input  wire logic signed [23:0]   target_x,
  input  wire logic signed [23:0]   target_y,
  output logic                      done,
  output logic signed [31:0]        curvature,
  output logic                      saturated,
  output logic                      coincident
);

  localparam int SW      = SINE_BITS + 2;
  localparam int SOUT_W  = SINE_BITS + 1;
  localparam int PR_W    = SW + pcurv_pkg::DX_W;
  localparam int NUM_W   = SINE_BITS + 29;
  localparam int FRAC_SH = 24 - SINE_BITS;
  localparam int LAT     = 5 + 3 * pcurv_pkg::HSTEPS + 2 + 3 + 1 + pcurv_pkg::QBITS + 1;

  assign busy = 1'b0;

  // input stage: differences, octant fold
  pcurv_pkg::side_t          s0;
  logic [pcurv_pkg::T_W-1:0] t0;
  logic signed [pcurv_pkg::DX_W-1:0] dx_in, dy_in;
  logic [pcurv_pkg::T_W-1:0] r_in;
  logic [pcurv_pkg::T_W:0]   r_mir;

  always_comb begin
    dx_in = {target_x[23], target_x} - {robot_x[23], robot_x};
    dy_in = {target_y[23], target_y} - {robot_y[23], robot_y};
    r_in  = heading[pcurv_pkg::T_W-1:0];
    r_mir = 15'd16384 - {1'b0, r_in};
  end

  always_ff @(posedge clk) begin
    s0.coinc  <= (dx_in == '0) && (dy_in == '0);
    s0.quad   <= heading[15:14];
    s0.mirror <= r_in > pcurv_pkg::OCTANT;
    s0.dx     <= dx_in;
    s0.dy     <= dy_in;
    s0.x      <= '0;
    s0.x2     <= '0;
    t0        <= (r_in > pcurv_pkg::OCTANT) ? r_mir[pcurv_pkg::T_W-1:0] : r_in;
    if (rst) s0.valid <= 1'b0;
    else     s0.valid <= start;
  end

  // angle to q30 radians
  pcurv_pkg::side_t           s1, s2, s3, s4;
  pcurv_pkg::side_t           s2_next, s4_next;
  logic [pcurv_pkg::XP_W-1:0] xprod;
  logic [pcurv_pkg::XSQ_W-1:0] xsq;

  always_ff @(posedge clk) begin
    s1    <= pcurv_pkg::side_pass(s0, rst);
    xprod <= t0 * pcurv_pkg::PI_Q32;
  end

  always_comb begin
    s2_next   = pcurv_pkg::side_pass(s1, rst);
    s2_next.x = pcurv_pkg::X_W'((xprod + 48'd65536) >> 17);
  end

  always_ff @(posedge clk) begin
    s2 <= s2_next;
  end

  always_ff @(posedge clk) begin
    s3  <= pcurv_pkg::side_pass(s2, rst);
    xsq <= s2.x * s2.x;
  end

  always_comb begin
    s4_next    = pcurv_pkg::side_pass(s3, rst);
    s4_next.x2 = pcurv_pkg::X_W'((xsq + (61'd1 << 29)) >> 30);
  end

  always_ff @(posedge clk) begin
    s4 <= s4_next;
  end

  // horner steps: multiply, reciprocal multiply, correct and subtract
  logic [pcurv_pkg::H_W-1:0] hs [0:pcurv_pkg::HSTEPS-1];
  logic [pcurv_pkg::H_W-1:0] hc [0:pcurv_pkg::HSTEPS-1];
  pcurv_pkg::side_t          hsb [0:pcurv_pkg::HSTEPS-1];

  for (genvar i = 0; i < pcurv_pkg::HSTEPS; i++) begin : g_horner
    localparam logic [63:0] SM64 = (64'd1 << 32) / 64'(pcurv_pkg::SDIV[i]);
    localparam logic [63:0] CM64 = (64'd1 << 32) / 64'(pcurv_pkg::CDIV[i]);
    localparam logic [pcurv_pkg::M_W-1:0] SM = SM64[pcurv_pkg::M_W-1:0];
    localparam logic [pcurv_pkg::M_W-1:0] CM = CM64[pcurv_pkg::M_W-1:0];

    logic [pcurv_pkg::H_W-1:0]  s_prev, c_prev;
    pcurv_pkg::side_t           sb_prev, sb_a, sb_b;
    logic [pcurv_pkg::HP_W-1:0] a_ps, a_pc;
    logic [pcurv_pkg::H_W-1:0]  b_ps, b_pc;
    logic [pcurv_pkg::PM_W-1:0] b_ms, b_mc;
    logic [30:0]                qs0, qc0;
    logic [39:0]                rs, rc;
    logic [pcurv_pkg::H_W-1:0]  qs, qc;

    if (i == 0) begin : g_first
      assign s_prev  = pcurv_pkg::Q30_ONE;
      assign c_prev  = pcurv_pkg::Q30_ONE;
      assign sb_prev = s4;
    end else begin : g_rest
      assign s_prev  = hs[i-1];
      assign c_prev  = hc[i-1];
      assign sb_prev = hsb[i-1];
    end

    // x2 times the running terms
    always_ff @(posedge clk) begin
      sb_a <= pcurv_pkg::side_pass(sb_prev, rst);
      a_ps <= sb_prev.x2 * s_prev;
      a_pc <= sb_prev.x2 * c_prev;
    end

    // reciprocal estimate of the quotient
    always_ff @(posedge clk) begin
      sb_b <= pcurv_pkg::side_pass(sb_a, rst);
      b_ps <= pcurv_pkg::H_W'(a_ps >> 30);
      b_pc <= pcurv_pkg::H_W'(a_pc >> 30);
      b_ms <= pcurv_pkg::H_W'(a_ps >> 30) * SM;
      b_mc <= pcurv_pkg::H_W'(a_pc >> 30) * CM;
    end

    // estimate is low by at most one
    always_comb begin
      qs0 = b_ms[62:32];
      qc0 = b_mc[62:32];
      rs  = {9'd0, b_ps} - qs0 * pcurv_pkg::SDIV[i];
      rc  = {9'd0, b_pc} - qc0 * pcurv_pkg::CDIV[i];
      qs  = qs0 + pcurv_pkg::H_W'(rs >= 40'(pcurv_pkg::SDIV[i]));
      qc  = qc0 + pcurv_pkg::H_W'(rc >= 40'(pcurv_pkg::CDIV[i]));
    end

    always_ff @(posedge clk) begin
      hsb[i] <= pcurv_pkg::side_pass(sb_b, rst);
      hs[i]  <= pcurv_pkg::Q30_ONE - qs;
      hc[i]  <= pcurv_pkg::Q30_ONE - qc;
    end
  end

  // sine times x, then round and apply quadrant
  localparam int LAST = pcurv_pkg::HSTEPS - 1;
  pcurv_pkg::side_t           f1, f2;
  logic [pcurv_pkg::HP_W-1:0] f1_s;
  logic [pcurv_pkg::H_W-1:0]  f1_c;
  logic [31:0]                half, s_rnd, c_rnd;
  logic [SOUT_W-1:0]          s_u0, c_u0, s_u, c_u;
  logic signed [SW-1:0]       sp, cp, sn_next, cs_next;
  logic signed [SW-1:0]       sn, cs;

  always_ff @(posedge clk) begin
    f1   <= pcurv_pkg::side_pass(hsb[LAST], rst);
    f1_s <= hsb[LAST].x * hs[LAST];
    f1_c <= hc[LAST];
  end

  always_comb begin
    half  = 32'd1 << (29 - SINE_BITS);
    s_rnd = 32'(f1_s >> 30) + half;
    c_rnd = 32'(f1_c) + half;
    s_u0  = SOUT_W'(s_rnd >> (30 - SINE_BITS));
    c_u0  = SOUT_W'(c_rnd >> (30 - SINE_BITS));
    s_u   = f1.mirror ? c_u0 : s_u0;
    c_u   = f1.mirror ? s_u0 : c_u0;
    sp    = $signed({1'b0, s_u});
    cp    = $signed({1'b0, c_u});
    unique case (f1.quad)
      pcurv_pkg::QUAD_0: begin sn_next = sp;  cs_next = cp;  end
      pcurv_pkg::QUAD_1: begin sn_next = cp;  cs_next = -sp; end
      pcurv_pkg::QUAD_2: begin sn_next = -sp; cs_next = -cp; end
      pcurv_pkg::QUAD_3: begin sn_next = -cp; cs_next = sp;  end
      default:           begin sn_next = sp;  cs_next = cp;  end
    endcase
  end

  always_ff @(posedge clk) begin
    f2 <= pcurv_pkg::side_pass(f1, rst);
    sn <= sn_next;
    cs <= cs_next;
  end

  // cross product and squared distance
  logic                       n1_valid, n1_coinc, n2_valid, n2_coinc;
  logic signed [PR_W-1:0]     pa, pb;
  logic signed [49:0]         sq_dx, sq_dy;
  logic [pcurv_pkg::SQ_W-1:0] ddx, ddy;
  logic signed [NUM_W-1:0]    num;
  logic [pcurv_pkg::DEN_W-1:0] den;

  always_comb begin
    sq_dx = f2.dx * f2.dx;
    sq_dy = f2.dy * f2.dy;
  end

  always_ff @(posedge clk) begin
    n1_coinc <= f2.coinc;
    pa       <= sn * f2.dx;
    pb       <= cs * f2.dy;
    ddx      <= sq_dx[pcurv_pkg::SQ_W-1:0];
    ddy      <= sq_dy[pcurv_pkg::SQ_W-1:0];
    if (rst) n1_valid <= 1'b0;
    else     n1_valid <= f2.valid;
  end

  always_ff @(posedge clk) begin
    n2_coinc <= n1_coinc;
    num      <= (pa - pb) <<< 1;
    den      <= {1'b0, ddx} + {1'b0, ddy};
    if (rst) n2_valid <= 1'b0;
    else     n2_valid <= n1_valid;
  end

  // magnitude, scaled dividend
  logic                        n3_valid, n3_coinc, n3_neg;
  logic [NUM_W-1:0]            num_abs;
  logic [pcurv_pkg::REM_W-1:0] n3_rem;
  logic [pcurv_pkg::DEN_W-1:0] n3_den;

  assign num_abs = num[NUM_W-1] ? -num : num;

  always_ff @(posedge clk) begin
    n3_coinc <= n2_coinc;
    n3_neg   <= num[NUM_W-1];
    n3_rem   <= pcurv_pkg::REM_W'(num_abs) << FRAC_SH;
    n3_den   <= den;
    if (rst) n3_valid <= 1'b0;
    else     n3_valid <= n2_valid;
  end

  // overflow check, then one quotient bit a stage
  pcurv_pkg::div_t             dvs [0:pcurv_pkg::QBITS];
  logic [pcurv_pkg::CMP_W-1:0] ovf_rem, ovf_den;

  always_comb begin
    ovf_rem = pcurv_pkg::CMP_W'(n3_rem);
    ovf_den = pcurv_pkg::CMP_W'(n3_den) << pcurv_pkg::QBITS;
  end

  always_ff @(posedge clk) begin
    dvs[0].coinc <= n3_coinc;
    dvs[0].neg   <= n3_neg;
    dvs[0].ovf   <= ovf_rem >= ovf_den;
    dvs[0].den   <= n3_den;
    dvs[0].rem   <= n3_rem;
    dvs[0].q     <= '0;
    if (rst) dvs[0].valid <= 1'b0;
    else     dvs[0].valid <= n3_valid;
  end

  for (genvar k = 0; k < pcurv_pkg::QBITS; k++) begin : g_div
    localparam int J = pcurv_pkg::QBITS - 1 - k;
    logic [pcurv_pkg::CMP_W-1:0] trial;
    logic                        hit;
    pcurv_pkg::div_t             dv_next;

    always_comb begin
      trial      = pcurv_pkg::CMP_W'(dvs[k].den) << J;
      hit        = pcurv_pkg::CMP_W'(dvs[k].rem) >= trial;
      dv_next    = dvs[k];
      dv_next.q[J] = hit;
      if (hit) dv_next.rem = dvs[k].rem - trial[pcurv_pkg::REM_W-1:0];
      if (rst) dv_next.valid = 1'b0;
    end

    always_ff @(posedge clk) begin
      dvs[k+1] <= dv_next;
    end
  end

  // round half away, clip, sign
  pcurv_pkg::div_t dl;
  logic            rnd, sat_next;
  logic [32:0]     qr, lim, qv;
  logic [31:0]     mag32;

  always_comb begin
    dl       = dvs[pcurv_pkg::QBITS];
    rnd      = {dl.rem, 1'b0} >= (pcurv_pkg::REM_W + 1)'(dl.den);
    qr       = {1'b0, dl.q} + 33'(rnd);
    lim      = dl.neg ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
    sat_next = dl.ovf || (qr > lim);
    qv       = sat_next ? lim : qr;
    mag32    = qv[31:0];
  end

  always_ff @(posedge clk) begin
    if (dl.coinc) begin
      curvature  <= '0;
      saturated  <= 1'b0;
      coincident <= 1'b1;
    end else begin
      curvature  <= dl.neg ? -$signed(mag32) : $signed(mag32);
      saturated  <= sat_next;
      coincident <= 1'b0;
    end
    if (rst) done <= 1'b0;
    else     done <= dl.valid;
  end

  // checks
  a_lat : assert property (@(posedge clk) disable iff (rst) start |-> ##LAT done)
    else $error("beat did not leave after pipeline latency");
  a_src : assert property (@(posedge clk) disable iff (rst) done |-> $past(start, LAT))
    else $error("result without an input beat");
  a_coinc : assert property (@(posedge clk) disable iff (rst)
    done && coincident |-> curvature == 32'sd0 && !saturated)
    else $error("coincident result not zero");
  a_sat : assert property (@(posedge clk) disable iff (rst)
    done && saturated |-> curvature == 32'sh7FFF_FFFF || curvature == 32'sh8000_0000)
    else $error("saturated result not at a range end");

endmodule

`default_nettype wire
